// ----- hdl/lswc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared types and codes for the line segment window clipper: region codes,
// register indexes, clip edges and sequencer states.
// ----------------------------------------------------------------------------
package lswc_pkg;

   // four-bit region code of one endpoint
   typedef logic [3:0] lswc_code_type;

   localparam lswc_code_type CODE_NONE   = 4'b0000;
   localparam lswc_code_type CODE_LEFT   = 4'b0001;
   localparam lswc_code_type CODE_RIGHT  = 4'b0010;
   localparam lswc_code_type CODE_BOTTOM = 4'b0100;
   localparam lswc_code_type CODE_TOP    = 4'b1000;

   // configuration register indexes
   typedef logic [1:0] lswc_csr_type;

   localparam lswc_csr_type CSR_WINDOW_LEFT   = 2'd0;
   localparam lswc_csr_type CSR_WINDOW_BOTTOM = 2'd1;
   localparam lswc_csr_type CSR_WINDOW_RIGHT  = 2'd2;
   localparam lswc_csr_type CSR_WINDOW_TOP    = 2'd3;

   // window edge an endpoint is moved onto
   typedef enum logic [1:0] {
      EDGE_TOP,
      EDGE_BOTTOM,
      EDGE_RIGHT,
      EDGE_LEFT
   } lswc_edge_type;

   // top level sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEST,
      ST_WAIT,
      ST_DONE
   } lswc_state_type;

   // multiply-divide unit sequencer
   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_FIN
   } lswc_md_state_type;

endpackage
`default_nettype wire

// ----- hdl/lswc_muldiv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lswc_muldiv
// Iterative signed trunc(a * b / c) with one shared adder: shift-add multiply,
// then restoring division, result clamped to a safe magnitude.
// ----------------------------------------------------------------------------
module lswc_muldiv
   import lswc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [COORD_BITS:0]  a,
   input  wire logic signed [COORD_BITS:0]  b,
   input  wire logic signed [COORD_BITS:0]  c,
   output logic                             done,
   output logic signed [COORD_BITS+1:0]     result
);

   localparam int N  = COORD_BITS;
   localparam int DW = N + 1;
   localparam int RW = N + 2;
   localparam int PW = 2 * N;
   localparam int CW = $clog2(PW);

   lswc_md_state_type st_ff, st_in;
   logic [PW-1:0]     p_ff, p_in;
   logic [N-1:0]      rem_ff, rem_in;
   logic [N-1:0]      mb_ff, mb_in;
   logic [N-1:0]      mc_ff, mc_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   logic [N-1:0]      ma, mb, mc;
   logic [N:0]        rem_sh;
   logic [N+1:0]      add_a, add_b, add_y;
   logic              add_sub;
   logic              div_ok;
   logic [N:0]        hi_sum;
   logic [N:0]        mag;
   logic [RW-1:0]     mag_ext;

   // operand magnitudes, each below 2^N
   assign ma = a[DW-1] ? (~a[N-1:0] + N'(1)) : a[N-1:0];
   assign mb = b[DW-1] ? (~b[N-1:0] + N'(1)) : b[N-1:0];
   assign mc = c[DW-1] ? (~c[N-1:0] + N'(1)) : c[N-1:0];

   assign rem_sh = {rem_ff, p_ff[PW-1]};

   // the one shared adder
   always_comb begin
      if (st_ff == MD_DIV) begin
         add_a   = {1'b0, rem_sh};
         add_b   = {2'b00, mc_ff};
         add_sub = 1'b1;
      end else begin
         add_a   = {2'b00, p_ff[PW-1:N]};
         add_b   = {2'b00, mb_ff};
         add_sub = 1'b0;
      end
      add_y = add_a + (add_sub ? ~add_b : add_b) + (N+2)'(add_sub);
   end

   assign div_ok = ~add_y[N+1];
   assign hi_sum = p_ff[0] ? add_y[N:0] : {1'b0, p_ff[PW-1:N]};

   // clamp quotient; anything at or above 2^(N+1) saturates downstream anyway
   assign mag     = (|p_ff[PW-1:N+1]) ? {(N+1){1'b1}} : p_ff[N:0];
   assign mag_ext = {1'b0, mag};

   always_comb begin
      st_in   = st_ff;
      p_in    = p_ff;
      rem_in  = rem_ff;
      mb_in   = mb_ff;
      mc_in   = mc_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      done    = 1'b0;
      result  = '0;
      unique case (st_ff)
         MD_IDLE: begin
            if (start) begin
               p_in    = {{N{1'b0}}, ma};
               mb_in   = mb;
               mc_in   = mc;
               neg_in  = a[DW-1] ^ b[DW-1] ^ c[DW-1];
               zero_in = (mc == '0);
               cnt_in  = '0;
               st_in   = MD_MUL;
            end
         end
         MD_MUL: begin
            p_in = {hi_sum, p_ff[N-1:1]};
            if (cnt_ff == CW'(N - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               st_in  = MD_DIV;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         MD_DIV: begin
            rem_in = div_ok ? add_y[N-1:0] : rem_sh[N-1:0];
            p_in   = {p_ff[PW-2:0], div_ok};
            if (cnt_ff == CW'(PW - 1)) begin
               st_in = MD_FIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         MD_FIN: begin
            done = 1'b1;
            if (zero_ff) begin
               result = '0;
            end else if (neg_ff) begin
               result = ~mag_ext + RW'(1);
            end else begin
               result = mag_ext;
            end
            st_in = MD_IDLE;
         end
         default: begin
            st_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= MD_IDLE;
      end else begin
         st_ff <= st_in;
      end
      p_ff    <= p_in;
      rem_ff  <= rem_in;
      mb_ff   <= mb_in;
      mc_ff   <= mc_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
   end

endmodule
`default_nettype wire

// ----- hdl/line_segment_window_clipper.sv -----
`default_nettype none
// clips: each accepted item takes 0 to MAX_PASSES edge clips before its result,
//   which is then written to the output register
// each clip: one region test, then COORD_BITS multiply steps, 2 * COORD_BITS
//   divide steps and a finish step in the shared multiply-divide unit
// throughput: one item at a time; next item taken once the result is in the output register
// reset: synchronous, clears control state and loads the window 100/200/500/400
// ----------------------------------------------------------------------------
// line_segment_window_clipper
// Cohen-Sutherland clipping of one segment against a configurable window,
// intersections computed by an iterative multiply-divide unit.
// ----------------------------------------------------------------------------
module line_segment_window_clipper
   import lswc_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int MAX_PASSES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration writes
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [COORD_BITS-1:0]         csr_wdata,
   // segment in
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_BITS-1:0]  req_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_end_y,
   // clipped segment out
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_accepted,
   output logic                               rsp_pass_overrun,
   output logic signed [COORD_BITS-1:0]       rsp_clipped_start_x,
   output logic signed [COORD_BITS-1:0]       rsp_clipped_start_y,
   output logic signed [COORD_BITS-1:0]       rsp_clipped_end_x,
   output logic signed [COORD_BITS-1:0]       rsp_clipped_end_y
);

   localparam int N   = COORD_BITS;
   localparam int DW  = N + 1;
   localparam int RW  = N + 2;
   localparam int PCW = $clog2(MAX_PASSES + 1);

   // window registers
   logic signed [N-1:0] win_left_ff, win_bottom_ff, win_right_ff, win_top_ff;

   // sequencer and working endpoints
   lswc_state_type      st_ff, st_in;
   logic signed [N-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [N-1:0] x1_in, y1_in, x2_in, y2_in;
   logic [PCW-1:0]      pass_ff, pass_in;
   lswc_edge_type       edge_ff, edge_in;
   logic                first_ff, first_in;
   logic                acc_ff, acc_in;
   logic                over_ff, over_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic                rsp_over_ff, rsp_over_in;
   logic signed [N-1:0] rsp_sx_ff, rsp_sy_ff, rsp_ex_ff, rsp_ey_ff;
   logic signed [N-1:0] rsp_sx_in, rsp_sy_in, rsp_ex_in, rsp_ey_in;

   // region codes and edge choice
   lswc_code_type       code1, code2, code_pick;
   lswc_edge_type       edge_sel;
   logic                sel_vert, cur_vert;

   // multiply-divide unit hookup
   logic                md_start, md_done;
   logic signed [DW-1:0] md_a, md_b, md_c;
   logic signed [RW-1:0] md_result;
   logic signed [DW-1:0] dx, dy;
   logic signed [N-1:0]  sel_edge_val, cur_edge_val;

   // new coordinate after a clip
   logic signed [N-1:0]  base;
   logic [N+2:0]         sat_sum;
   logic                 sat_fits;
   logic signed [N-1:0]  sat_val;
   logic signed [N-1:0]  nx, ny;

   function automatic logic signed [DW-1:0] ext1(input logic signed [N-1:0] v);
      return {v[N-1], v};
   endfunction

   function automatic lswc_code_type region(
      input logic signed [N-1:0] x,
      input logic signed [N-1:0] y,
      input logic signed [N-1:0] lft,
      input logic signed [N-1:0] rgt,
      input logic signed [N-1:0] bot,
      input logic signed [N-1:0] tp
   );
      lswc_code_type c;
      c = CODE_NONE;
      if (x < lft) begin
         c = c | CODE_LEFT;
      end else if (x > rgt) begin
         c = c | CODE_RIGHT;
      end
      if (y < bot) begin
         c = c | CODE_BOTTOM;
      end else if (y > tp) begin
         c = c | CODE_TOP;
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= N'(100);
         win_bottom_ff <= N'(200);
         win_right_ff  <= N'(500);
         win_top_ff    <= N'(400);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LEFT:   win_left_ff   <= csr_wdata;
            CSR_WINDOW_BOTTOM: win_bottom_ff <= csr_wdata;
            CSR_WINDOW_RIGHT:  win_right_ff  <= csr_wdata;
            CSR_WINDOW_TOP:    win_top_ff    <= csr_wdata;
            default:           win_left_ff   <= win_left_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // region test and edge choice
   // ---------------------------------------------------------------------------
   assign code1 = region(x1_ff, y1_ff, win_left_ff, win_right_ff, win_bottom_ff, win_top_ff);
   assign code2 = region(x2_ff, y2_ff, win_left_ff, win_right_ff, win_bottom_ff, win_top_ff);

   // first endpoint moves if it is outside, else the second one
   assign code_pick = (code1 != CODE_NONE) ? code1 : code2;

   always_comb begin
      priority if ((code_pick & CODE_TOP) != CODE_NONE) begin
         edge_sel = EDGE_TOP;
      end else if ((code_pick & CODE_BOTTOM) != CODE_NONE) begin
         edge_sel = EDGE_BOTTOM;
      end else if ((code_pick & CODE_RIGHT) != CODE_NONE) begin
         edge_sel = EDGE_RIGHT;
      end else begin
         edge_sel = EDGE_LEFT;
      end
   end

   function automatic logic signed [N-1:0] edge_value(
      input lswc_edge_type e,
      input logic signed [N-1:0] lft,
      input logic signed [N-1:0] rgt,
      input logic signed [N-1:0] bot,
      input logic signed [N-1:0] tp
   );
      logic signed [N-1:0] v;
      unique case (e)
         EDGE_TOP:    v = tp;
         EDGE_BOTTOM: v = bot;
         EDGE_RIGHT:  v = rgt;
         EDGE_LEFT:   v = lft;
         default:     v = lft;
      endcase
      return v;
   endfunction

   assign sel_vert     = (edge_sel == EDGE_TOP) || (edge_sel == EDGE_BOTTOM);
   assign cur_vert     = (edge_ff == EDGE_TOP) || (edge_ff == EDGE_BOTTOM);
   assign sel_edge_val = edge_value(edge_sel, win_left_ff, win_right_ff,
                                    win_bottom_ff, win_top_ff);
   assign cur_edge_val = edge_value(edge_ff, win_left_ff, win_right_ff,
                                    win_bottom_ff, win_top_ff);

   // ---------------------------------------------------------------------------
   // operands: top/bottom gives x1 + dx * (edge - y1) / dy,
   // right/left gives y1 + dy * (edge - x1) / dx
   // ---------------------------------------------------------------------------
   assign dx = ext1(x2_ff) - ext1(x1_ff);
   assign dy = ext1(y2_ff) - ext1(y1_ff);

   assign md_a = sel_vert ? dx : dy;
   assign md_c = sel_vert ? dy : dx;
   assign md_b = ext1(sel_edge_val) - (sel_vert ? ext1(y1_ff) : ext1(x1_ff));

   lswc_muldiv #(
      .COORD_BITS (COORD_BITS)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .a      (md_a),
      .b      (md_b),
      .c      (md_c),
      .done   (md_done),
      .result (md_result)
   );

   // base plus quotient, saturated to the coordinate range
   assign base     = cur_vert ? x1_ff : y1_ff;
   assign sat_sum  = {{3{base[N-1]}}, base} + {md_result[RW-1], md_result};
   assign sat_fits = (sat_sum[N+2:N-1] == '0) || (sat_sum[N+2:N-1] == '1);
   assign sat_val  = sat_fits ? sat_sum[N-1:0]
                   : (sat_sum[N+2] ? {1'b1, {(N-1){1'b0}}} : {1'b0, {(N-1){1'b1}}});

   assign nx = cur_vert ? sat_val : cur_edge_val;
   assign ny = cur_vert ? cur_edge_val : sat_val;

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      st_in        = st_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      pass_in      = pass_ff;
      edge_in      = edge_ff;
      first_in     = first_ff;
      acc_in       = acc_ff;
      over_in      = over_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_sx_in    = rsp_sx_ff;
      rsp_sy_in    = rsp_sy_ff;
      rsp_ex_in    = rsp_ex_ff;
      rsp_ey_in    = rsp_ey_ff;
      md_start     = 1'b0;
      req_ready    = 1'b0;

      // item taken downstream
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               x1_in   = req_start_x;
               y1_in   = req_start_y;
               x2_in   = req_end_x;
               y2_in   = req_end_y;
               pass_in = '0;
               st_in   = ST_TEST;
            end
         end
         ST_TEST: begin
            priority if ((code1 == CODE_NONE) && (code2 == CODE_NONE)) begin
               // trivially inside
               acc_in  = 1'b1;
               over_in = 1'b0;
               st_in   = ST_DONE;
            end else if ((code1 & code2) != CODE_NONE) begin
               // both endpoints beyond the same edge
               acc_in  = 1'b0;
               over_in = 1'b0;
               st_in   = ST_DONE;
            end else if (pass_ff == PCW'(MAX_PASSES)) begin
               acc_in  = 1'b0;
               over_in = 1'b1;
               st_in   = ST_DONE;
            end else begin
               md_start = 1'b1;
               edge_in  = edge_sel;
               first_in = (code1 != CODE_NONE);
               st_in    = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (md_done) begin
               if (first_ff) begin
                  x1_in = nx;
                  y1_in = ny;
               end else begin
                  x2_in = nx;
                  y2_in = ny;
               end
               pass_in = pass_ff + PCW'(1);
               st_in   = ST_TEST;
            end
         end
         ST_DONE: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_over_in  = over_ff;
               rsp_sx_in    = acc_ff ? x1_ff : '0;
               rsp_sy_in    = acc_ff ? y1_ff : '0;
               rsp_ex_in    = acc_ff ? x2_ff : '0;
               rsp_ey_in    = acc_ff ? y2_ff : '0;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      pass_ff     <= pass_in;
      edge_ff     <= edge_in;
      first_ff    <= first_in;
      acc_ff      <= acc_in;
      over_ff     <= over_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_over_ff <= rsp_over_in;
      rsp_sx_ff   <= rsp_sx_in;
      rsp_sy_ff   <= rsp_sy_in;
      rsp_ex_ff   <= rsp_ex_in;
      rsp_ey_ff   <= rsp_ey_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_pass_overrun    = rsp_over_ff;
   assign rsp_clipped_start_x = rsp_sx_ff;
   assign rsp_clipped_start_y = rsp_sy_ff;
   assign rsp_clipped_end_x   = rsp_ex_ff;
   assign rsp_clipped_end_y   = rsp_ey_ff;

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
   a_accept_starts_test: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (st_ff == ST_TEST))
      else $error("accepted item did not start the region test");

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (st_ff == ST_WAIT))
      else $error("multiply-divide finished outside the wait state");

   a_overrun_is_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pass_overrun) |-> !rsp_accepted)
      else $error("pass overrun flagged on an accepted segment");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> ((rsp_clipped_start_x == '0) &&
         (rsp_clipped_start_y == '0) && (rsp_clipped_end_x == '0) &&
         (rsp_clipped_end_y == '0)))
      else $error("rejected segment carries nonzero endpoints");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_WAIT) |-> (pass_ff < PCW'(MAX_PASSES)))
      else $error("clip started beyond the pass limit");
`endif

endmodule
`default_nettype wire
